[rtl/dfd_pkg.sv]
// Shared types and constants for the delimited frame deframer.
package dfd_pkg;

	// Frame length ceiling and count saturation limit
	localparam int unsigned MaxFrameLen = 256;
	localparam int unsigned CountLimit  = 65535;

	localparam logic [7:0] HeaderReset  = 8'd36;
	localparam logic [7:0] TrailerReset = 8'd10;
	localparam logic [7:0] StrCmdReset  = 8'd83;
	localparam logic [8:0] MaxLenReset  = 9'd256;

	localparam logic [7:0] CharComma = 8'd44;
	localparam logic [7:0] CharPlus  = 8'd43;
	localparam logic [7:0] CharMinus = 8'd45;
	localparam logic [7:0] CharZero  = 8'd48;
	localparam logic [7:0] CharNine  = 8'd57;
	localparam logic [7:0] CharSpace = 8'd32;
	localparam logic [7:0] CharTab   = 8'd9;
	localparam logic [7:0] CharCr    = 8'd13;

	// Output beat tag
	typedef enum logic [2:0] {
		KIND_HEADER  = 3'd0,
		KIND_COMMAND = 3'd1,
		KIND_TEXT    = 3'd2,
		KIND_TRAILER = 3'd3,
		KIND_BINARY  = 3'd4,
		KIND_NONE    = 3'd5
	} kind_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_HEADER  = 2'd0,
		REG_TRAILER = 2'd1,
		REG_STR_CMD = 2'd2,
		REG_MAX_LEN = 2'd3
	} cfg_reg_t;

	// Decimal count parser phases
	typedef enum logic [2:0] {
		CP_FIRST  = 3'd0,
		CP_SEEK   = 3'd1,
		CP_PRE    = 3'd2,
		CP_DIGITS = 3'd3,
		CP_DONE   = 3'd4
	} count_phase_t;

	// Control from the frame tracker to the count parser
	typedef struct packed {
		logic       start;
		logic       step;
		logic [7:0] c;
	} count_ctl_t;

endpackage

[rtl/dfd_in_if.sv]
// Input byte channel: valid/ready with one received byte per beat.
interface dfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

[rtl/dfd_out_if.sv]
// Output channel: valid/ready with one tagged frame byte per beat.
interface dfd_out_if import dfd_pkg::*;;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	kind_t       kind;
	logic        frame_end;
	logic        abort_open;
	logic [15:0] binary_length;

	modport source (output valid, output out_byte, output kind, output frame_end,
		output abort_open, output binary_length, input ready);
	modport sink   (input valid, input out_byte, input kind, input frame_end,
		input abort_open, input binary_length, output ready);
	modport mon    (input valid, input out_byte, input kind, input frame_end,
		input abort_open, input binary_length, input ready);
endinterface

[rtl/dfd_count.sv]
// Decimal count parser: finds the number after the payload's comma, atoi style.
module dfd_count import dfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  count_ctl_t  ctl,
	output logic [15:0] count
);

	count_phase_t phase_q, phase_d;
	logic         neg_q, neg_d;
	logic [15:0]  value_q, value_d;

	logic         digit;
	logic         space;
	logic [19:0]  acc;
	logic [15:0]  acc_sat;

	assign digit = (ctl.c >= CharZero) && (ctl.c <= CharNine);
	assign space = (ctl.c == CharSpace) || ((ctl.c >= CharTab) && (ctl.c <= CharCr));

	// times ten accumulate, saturating
	assign acc = ({4'd0, value_q} << 3) + ({4'd0, value_q} << 1)
		+ {12'd0, ctl.c - CharZero};
	assign acc_sat = (acc > 20'(CountLimit)) ? 16'(CountLimit) : acc[15:0];

	// count is valid once the comma was passed and the sign is not negative
	assign count = (((phase_q == CP_PRE) || (phase_q == CP_DIGITS) || (phase_q == CP_DONE))
		&& !neg_q) ? value_q : 16'd0;

	// next parser state
	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		value_d = value_q;
		if (ctl.start) begin
			phase_d = CP_FIRST;
			neg_d   = 1'b0;
			value_d = 16'd0;
		end else if (ctl.step) begin
			unique case (phase_q)
				CP_FIRST: phase_d = CP_SEEK;
				CP_SEEK: begin
					if (ctl.c == CharComma) phase_d = CP_PRE;
				end
				CP_PRE: begin
					priority if (space) begin
						phase_d = CP_PRE;
					end else if ((ctl.c == CharPlus) || (ctl.c == CharMinus)) begin
						neg_d   = (ctl.c == CharMinus);
						phase_d = CP_DIGITS;
					end else if (digit) begin
						value_d = acc_sat;
						phase_d = CP_DIGITS;
					end else begin
						phase_d = CP_DONE;
					end
				end
				CP_DIGITS: begin
					if (digit) value_d = acc_sat;
					else phase_d = CP_DONE;
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= CP_FIRST;
			neg_q   <= 1'b0;
			value_q <= 16'd0;
		end else begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			value_q <= value_d;
		end
	end

endmodule

[rtl/delimited_frame_deframer.sv]
// Top level: byte stream to tagged frame bytes with end and abort marks.
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one byte per cycle while the output is not stalled; the frame tracker decides each byte in one pass.
// Input ready is high while the output register is empty or being drained.
// Bytes that produce no result are still accepted and leave the output register empty.
// Reset (arst_n low) closes any frame, clears counters and restores register defaults.
module delimited_frame_deframer import dfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	dfd_in_if.sink      byte_ch,
	dfd_out_if.source   frame_ch
);

	// configuration registers
	logic [7:0] header_q, trailer_q, str_cmd_q;
	logic [8:0] max_len_q;

	// frame state
	logic        open_q, open_d;
	logic [8:0]  len_q, len_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] bin_rem_q, bin_rem_d;

	// output register
	logic        res_valid_q;
	logic [7:0]  res_byte_q;
	kind_t       res_kind_q;
	logic        res_end_q, res_abort_q;
	logic [15:0] res_blen_q;

	logic        accept;
	logic        emit;
	logic [7:0]  r_byte;
	kind_t       r_kind;
	logic        r_end, r_abort;
	logic [15:0] r_blen;

	logic [7:0]  c;
	logic [8:0]  limit;
	logic [9:0]  len_n;
	logic [15:0] count;
	count_ctl_t  cctl;

	assign c       = byte_ch.data_byte;
	assign byte_ch.ready = !res_valid_q || frame_ch.ready;
	assign accept  = byte_ch.valid && byte_ch.ready;
	assign limit   = (max_len_q > 9'(MaxFrameLen)) ? 9'(MaxFrameLen) : max_len_q;
	assign len_n   = {1'b0, len_q} + 10'd1;

	dfd_count u_count (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.count  (count)
	);

	// per-byte decision
	always_comb begin
		open_d    = open_q;
		len_d     = len_q;
		cmd_d     = cmd_q;
		bin_rem_d = bin_rem_q;
		emit      = 1'b0;
		r_byte    = c;
		r_kind    = KIND_NONE;
		r_end     = 1'b0;
		r_abort   = 1'b0;
		r_blen    = 16'd0;
		cctl      = '{start: 1'b0, step: 1'b0, c: c};
		if (accept) begin
			emit = 1'b1;
			priority if (bin_rem_q != 16'd0) begin
				bin_rem_d = bin_rem_q - 16'd1;
				r_kind    = KIND_BINARY;
				r_end     = (bin_rem_q == 16'd1);
			end else if (c == header_q) begin
				// header opens a frame, discarding any open one
				open_d     = 1'b1;
				len_d      = 9'd1;
				cmd_d      = 8'd0;
				cctl.start = 1'b1;
				r_kind     = KIND_HEADER;
				r_abort    = open_q;
			end else if (!open_q) begin
				emit = 1'b0;
			end else if (len_n > {1'b0, limit}) begin
				// too long
				open_d  = 1'b0;
				len_d   = 9'd0;
				r_byte  = 8'd0;
				r_abort = 1'b1;
			end else if (c == trailer_q) begin
				open_d = 1'b0;
				len_d  = 9'd0;
				priority if (len_n < 10'd3) begin
					r_byte  = 8'd0;
					r_abort = 1'b1;
				end else if (cmd_q != str_cmd_q) begin
					r_kind = KIND_TRAILER;
					r_end  = 1'b1;
				end else begin
					r_kind    = KIND_TRAILER;
					bin_rem_d = count;
					r_blen    = count;
					r_end     = (count == 16'd0);
				end
			end else if (len_n == 10'd2) begin
				len_d  = len_n[8:0];
				cmd_d  = c;
				r_kind = KIND_COMMAND;
			end else begin
				len_d     = len_n[8:0];
				cctl.step = 1'b1;
				r_kind    = KIND_TEXT;
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= HeaderReset;
			trailer_q <= TrailerReset;
			str_cmd_q <= StrCmdReset;
			max_len_q <= MaxLenReset;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HEADER:  header_q  <= cfg_data[7:0];
				REG_TRAILER: trailer_q <= cfg_data[7:0];
				REG_STR_CMD: str_cmd_q <= cfg_data[7:0];
				REG_MAX_LEN: max_len_q <= cfg_data;
			endcase
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			len_q     <= 9'd0;
			cmd_q     <= 8'd0;
			bin_rem_q <= 16'd0;
		end else begin
			open_q    <= open_d;
			len_q     <= len_d;
			cmd_q     <= cmd_d;
			bin_rem_q <= bin_rem_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (byte_ch.ready) begin
			res_valid_q <= emit;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (byte_ch.ready && emit) begin
			res_byte_q  <= r_byte;
			res_kind_q  <= r_kind;
			res_end_q   <= r_end;
			res_abort_q <= r_abort;
			res_blen_q  <= r_blen;
		end
	end

	assign frame_ch.valid         = res_valid_q;
	assign frame_ch.out_byte      = res_byte_q;
	assign frame_ch.kind          = res_kind_q;
	assign frame_ch.frame_end     = res_end_q;
	assign frame_ch.abort_open    = res_abort_q;
	assign frame_ch.binary_length = res_blen_q;

endmodule

[rtl/dfd_checker.sv]
// Port-level checks on the deframer output, bound to the top level.
module dfd_checker import dfd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [7:0]  out_byte,
	input kind_t       kind,
	input logic        frame_end,
	input logic        abort_open,
	input logic [15:0] binary_length
);

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(out_byte)
			&& $stable(kind) && $stable(binary_length))
		else $error("stalled output beat changed");

	// a discard beat carries no byte and always aborts
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_NONE) |->
			(out_byte == 8'd0) && abort_open && !frame_end)
		else $error("bad discard beat");

	// a binary count only rides on a trailer that does not end the frame
	a_blen: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (binary_length != 16'd0) |->
			(kind == KIND_TRAILER) && !frame_end)
		else $error("binary length on wrong beat");

	// frames end only on a trailer or a binary byte
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid && frame_end |->
			(kind == KIND_TRAILER) || (kind == KIND_BINARY))
		else $error("frame end on wrong beat");

	// binary bytes never carry an abort
	a_bin: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_BINARY) |-> !abort_open)
		else $error("abort on binary beat");

endmodule

bind delimited_frame_deframer dfd_checker u_dfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.valid         (frame_ch.valid),
	.ready         (frame_ch.ready),
	.out_byte      (frame_ch.out_byte),
	.kind          (frame_ch.kind),
	.frame_end     (frame_ch.frame_end),
	.abort_open    (frame_ch.abort_open),
	.binary_length (frame_ch.binary_length)
);
